### src/lobm_pkg.sv
`timescale 1ns / 1ps
package lobm_pkg;

  localparam int ORDER_SLOTS_DEF  = 32;
  localparam int ARRIVAL_BITS_DEF = 32;
  localparam int AVAIL_W          = 40;

  typedef enum logic [1:0] {
    MODE_SUBMIT = 2'd0,
    MODE_CANCEL = 2'd1,
    MODE_QUERY  = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

  localparam logic [2:0] TYPE_LIMIT  = 3'd0;
  localparam logic [2:0] TYPE_GTC    = 3'd1;
  localparam logic [2:0] TYPE_MARKET = 3'd2;
  localparam logic [2:0] TYPE_IOC    = 3'd3;
  localparam logic [2:0] TYPE_FOK    = 3'd4;

  localparam logic [2:0] EV_ACK         = 3'd0;
  localparam logic [2:0] EV_REJECT      = 3'd1;
  localparam logic [2:0] EV_FILL        = 3'd2;
  localparam logic [2:0] EV_CANCELLED   = 3'd3;
  localparam logic [2:0] EV_CANCEL_MISS = 3'd4;
  localparam logic [2:0] EV_QUERY_FOUND = 3'd5;
  localparam logic [2:0] EV_QUERY_MISS  = 3'd6;

  localparam logic [3:0] REASON_NONE      = 4'd0;
  localparam logic [3:0] RSN_NO_ID        = 4'd1;
  localparam logic [3:0] WRONG_INSTRUMENT = 4'd2;
  localparam logic [3:0] RSN_BAD_QTY      = 4'd3;
  localparam logic [3:0] RSN_DUP_ID       = 4'd4;
  localparam logic [3:0] RSN_BAD_PRICE    = 4'd5;
  localparam logic [3:0] RSN_SELF_TRADE   = 4'd6;
  localparam logic [3:0] RSN_FOK_SHORT    = 4'd7;
  localparam logic [3:0] RSN_LEFTOVER     = 4'd8;
  localparam logic [3:0] BOOK_FULL        = 4'd9;

  typedef struct packed {
    logic [31:0]        oid;
    logic               side;
    logic signed [31:0] price;
    logic signed [31:0] remaining;
    logic [15:0]        participant;
  } slot_t;

  typedef struct packed {
    logic               cancel;
    logic [31:0]        oid;
    logic               side;
    logic               market;
    logic signed [31:0] price;
    logic [15:0]        participant;
  } scan_ctx_t;

  typedef struct packed {
    logic               found;
    slot_t              found_ent;
    logic               selfx;
    logic [AVAIL_W-1:0] avail;
    logic               free_found;
    logic               bid_p;
    slot_t              bid_ent;
    logic               ask_p;
    slot_t              ask_ent;
  } scan_res_t;

  typedef struct packed {
    logic [2:0]         event_kind;
    logic [31:0]        event_order_id;
    logic [31:0]        counter_order_id;
    logic               event_side;
    logic signed [31:0] event_price;
    logic signed [31:0] event_quantity;
    logic [3:0]         reason;
    logic signed [31:0] best_bid_price;
    logic               bid_present;
    logic signed [31:0] best_ask_price;
    logic               ask_present;
    logic               last;
  } res_t;

endpackage

### src/lobm_if.sv
`timescale 1ns / 1ps
interface lobm_order_if;
  logic               valid;
  logic               ready;
  logic [1:0]         mode;
  logic [31:0]        req_id;
  logic [15:0]        instrument_code;
  logic               side;
  logic [2:0]         order_type;
  logic signed [31:0] price;
  logic signed [31:0] quantity;
  logic [15:0]        participant_id;

  modport source(output valid, mode, req_id, instrument_code, side, order_type, price,
                 quantity, participant_id, input ready);
  modport sink(input valid, mode, req_id, instrument_code, side, order_type, price,
               quantity, participant_id, output ready);
endinterface

interface lobm_event_if;
  logic               valid;
  logic               ready;
  logic [2:0]         event_kind;
  logic [31:0]        event_order_id;
  logic [31:0]        counter_order_id;
  logic               event_side;
  logic signed [31:0] event_price;
  logic signed [31:0] event_quantity;
  logic [3:0]         reason;
  logic signed [31:0] best_bid_price;
  logic               bid_present;
  logic signed [31:0] best_ask_price;
  logic               ask_present;
  logic               last;

  modport source(output valid, event_kind, event_order_id, counter_order_id, event_side,
                 event_price, event_quantity, reason, best_bid_price, bid_present,
                 best_ask_price, ask_present, last, input ready);
  modport sink(input valid, event_kind, event_order_id, counter_order_id, event_side,
               event_price, event_quantity, reason, best_bid_price, bid_present,
               best_ask_price, ask_present, last, output ready);
endinterface

### src/lobm_slot_mem.sv
`timescale 1ns / 1ps
module lobm_slot_mem import lobm_pkg::*; #(
  parameter int ORDER_SLOTS  = ORDER_SLOTS_DEF,
  parameter int ARRIVAL_BITS = ARRIVAL_BITS_DEF,
  localparam int SLOT_W = $clog2(ORDER_SLOTS)
) (
  input  logic                    clk,
  input  logic                    we,
  input  logic                    arr_we,
  input  logic [SLOT_W-1:0]       wa,
  input  slot_t                   wd,
  input  logic [ARRIVAL_BITS-1:0] warr,
  input  logic                    re,
  input  logic [SLOT_W-1:0]       ra,
  output slot_t                   rd,
  output logic [ARRIVAL_BITS-1:0] rd_arr
);

  slot_t                   ent_mem [ORDER_SLOTS];
  logic [ARRIVAL_BITS-1:0] arr_mem [ORDER_SLOTS];

  always_ff @(posedge clk) begin
    if (we) begin
      ent_mem[wa] <= wd;
    end
    if (arr_we) begin
      arr_mem[wa] <= warr;
    end
    if (re) begin
      rd     <= ent_mem[ra];
      rd_arr <= arr_mem[ra];
    end
  end

endmodule

### src/lobm_scan.sv
`timescale 1ns / 1ps
module lobm_scan import lobm_pkg::*; #(
  parameter int ORDER_SLOTS  = ORDER_SLOTS_DEF,
  parameter int ARRIVAL_BITS = ARRIVAL_BITS_DEF,
  localparam int SLOT_W = $clog2(ORDER_SLOTS)
) (
  input  logic                    clk,
  input  logic                    clear,
  input  logic                    ent_vld,
  input  logic [SLOT_W-1:0]       ent_idx,
  input  logic                    ent_live,
  input  slot_t                   ent,
  input  logic [ARRIVAL_BITS-1:0] ent_arr,
  input  scan_ctx_t               ctx,
  output scan_res_t               res,
  output logic [SLOT_W-1:0]       found_idx,
  output logic [SLOT_W-1:0]       free_idx,
  output logic [SLOT_W-1:0]       bid_idx,
  output logic [SLOT_W-1:0]       ask_idx
);

  logic [ARRIVAL_BITS-1:0] bid_arr;
  logic [ARRIVAL_BITS-1:0] ask_arr;
  logic                    id_hit;
  logic                    excl;
  logic                    trad;
  logic                    bid_better;
  logic                    ask_better;

  always_comb begin
    id_hit = ent_live && (ent.oid == ctx.oid);
    // a cancelled order no longer counts toward the best prices
    excl   = ctx.cancel && id_hit;
    trad   = ent_live && (ent.side != ctx.side) &&
             (ctx.market || (ctx.side ? ($signed(ent.price) >= $signed(ctx.price))
                                      : ($signed(ent.price) <= $signed(ctx.price))));
    bid_better = ent_live && !excl && !ent.side &&
                 (!res.bid_p || ($signed(ent.price) > $signed(res.bid_ent.price)) ||
                  ((ent.price == res.bid_ent.price) && (ent_arr < bid_arr)));
    ask_better = ent_live && !excl && ent.side &&
                 (!res.ask_p || ($signed(ent.price) < $signed(res.ask_ent.price)) ||
                  ((ent.price == res.ask_ent.price) && (ent_arr < ask_arr)));
  end

  always_ff @(posedge clk) begin
    if (clear) begin
      res.found      <= 1'b0;
      res.selfx      <= 1'b0;
      res.avail      <= '0;
      res.free_found <= 1'b0;
      res.bid_p      <= 1'b0;
      res.ask_p      <= 1'b0;
    end else if (ent_vld) begin
      if (id_hit && !res.found) begin
        res.found     <= 1'b1;
        res.found_ent <= ent;
        found_idx     <= ent_idx;
      end
      if (trad) begin
        res.avail <= res.avail + {{(AVAIL_W-32){1'b0}}, ent.remaining};
        if (ent.participant == ctx.participant) begin
          res.selfx <= 1'b1;
        end
      end
      if (!ent_live && !res.free_found) begin
        res.free_found <= 1'b1;
        free_idx       <= ent_idx;
      end
      if (bid_better) begin
        res.bid_p   <= 1'b1;
        res.bid_ent <= ent;
        bid_arr     <= ent_arr;
        bid_idx     <= ent_idx;
      end
      if (ask_better) begin
        res.ask_p   <= 1'b1;
        res.ask_ent <= ent;
        ask_arr     <= ent_arr;
        ask_idx     <= ent_idx;
      end
    end
  end

endmodule

### src/limit_order_book_matcher_core.sv
`timescale 1ns / 1ps
// Each scan of the book reads every slot through the one slot read port.
// Cancel and query: one scan, then a single result.
// Submit: one scan, then a further scan of the book after each fill.
// One request at a time; ready is low from acceptance of a request whose mode is not
// MODE_NONE until its last result is registered for output; MODE_NONE keeps ready high.
// Synchronous reset empties the book, clears the arrival counter and sets the instrument to 1.
module limit_order_book_matcher_core import lobm_pkg::*; #(
  parameter int ORDER_SLOTS  = ORDER_SLOTS_DEF,
  parameter int ARRIVAL_BITS = ARRIVAL_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_wr_en,
  input  logic [15:0]   cfg_wr_data,
  lobm_order_if.sink    orders,
  lobm_event_if.source  events
);

  localparam int SLOT_W = $clog2(ORDER_SLOTS);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_DECIDE = 4'b0100,
    S_FLUSH  = 4'b1000
  } state_t;

  typedef enum logic [3:0] {
    P_CHECK = 4'b0001,
    P_FOK   = 4'b0010,
    P_MATCH = 4'b0100,
    P_REM   = 4'b1000
  } phase_t;

  state_t                  state;
  phase_t                  phase;
  phase_t                  phase_next;
  logic [15:0]             book_instr;
  logic [ORDER_SLOTS-1:0]  slot_valid;
  logic [ARRIVAL_BITS-1:0] arrival_ctr;

  logic [1:0]              it_mode;
  logic [31:0]             it_id;
  logic [15:0]             it_instr;
  logic                    it_side;
  logic [2:0]              it_type;
  logic signed [31:0]      it_price;
  logic signed [31:0]      it_qty;
  logic [15:0]             it_part;

  logic [SLOT_W-1:0]       scan_addr;
  logic                    issue_done;
  logic                    rd_vld;
  logic [SLOT_W-1:0]       rd_idx;

  res_t                    pend;
  logic                    pend_valid;
  logic                    flush_last;
  res_t                    flush_res;
  logic                    out_load;
  logic                    fill_pend;
  logic [31:0]             fill_cid;
  logic signed [31:0]      fill_price;
  logic signed [31:0]      fill_qty;
  res_t                    out_r;
  logic                    out_valid;

  slot_t                   rd_ent;
  logic [ARRIVAL_BITS-1:0] rd_arr;
  scan_ctx_t               ctx;
  scan_res_t               sres;
  logic [SLOT_W-1:0]       found_idx;
  logic [SLOT_W-1:0]       free_idx;
  logic [SLOT_W-1:0]       bid_idx;
  logic [SLOT_W-1:0]       ask_idx;

  logic                    accept;
  logic                    scan_clear;
  logic                    market;
  logic [15:0]             instr_eff;
  logic [3:0]              why;
  slot_t                   opp;
  logic [SLOT_W-1:0]       opp_idx;
  logic                    opp_p;
  logic                    opp_trad;
  logic signed [31:0]      traded;
  res_t                    d_res;
  logic                    d_emit;
  logic                    d_final;
  logic                    d_trade;
  logic                    d_rest;
  logic                    d_drop;
  logic                    do_decide;
  logic                    mem_we;
  logic [SLOT_W-1:0]       mem_wa;
  slot_t                   mem_wd;

  assign accept = orders.valid && orders.ready;
  assign orders.ready = (state == S_IDLE);
  assign market = (it_type == TYPE_MARKET);

  assign ctx.cancel      = (it_mode == MODE_CANCEL);
  assign ctx.oid         = it_id;
  assign ctx.side        = it_side;
  assign ctx.market      = market;
  assign ctx.price       = it_price;
  assign ctx.participant = it_part;

  assign opp      = it_side ? sres.bid_ent : sres.ask_ent;
  assign opp_p    = it_side ? sres.bid_p : sres.ask_p;
  assign opp_idx  = it_side ? bid_idx : ask_idx;
  assign opp_trad = market || (it_side ? ($signed(opp.price) >= it_price)
                                       : ($signed(opp.price) <= it_price));
  assign traded   = (it_qty < $signed(opp.remaining)) ? it_qty : opp.remaining;

  always_comb begin
    instr_eff = (it_instr == 16'd0) ? book_instr : it_instr;
    if (it_id == 32'd0) begin
      why = RSN_NO_ID;
    end else if (instr_eff != book_instr) begin
      why = WRONG_INSTRUMENT;
    end else if (it_qty <= 0) begin
      why = RSN_BAD_QTY;
    end else if (sres.found) begin
      why = RSN_DUP_ID;
    end else if (!market && (it_price <= 0)) begin
      why = RSN_BAD_PRICE;
    end else if ((it_part != 16'd0) && sres.selfx) begin
      why = RSN_SELF_TRADE;
    end else begin
      why = REASON_NONE;
    end
  end

  always_comb begin
    d_res = '0;
    d_res.event_order_id = it_id;
    d_res.event_side     = it_side;
    d_res.event_price    = it_price;
    d_res.event_quantity = it_qty;
    d_res.bid_present    = sres.bid_p;
    d_res.best_bid_price = sres.bid_p ? sres.bid_ent.price : 32'sd0;
    d_res.ask_present    = sres.ask_p;
    d_res.best_ask_price = sres.ask_p ? sres.ask_ent.price : 32'sd0;
    d_emit     = 1'b0;
    d_final    = 1'b0;
    d_trade    = 1'b0;
    d_rest     = 1'b0;
    d_drop     = 1'b0;
    phase_next = phase;
    if (it_mode == MODE_SUBMIT) begin
      unique case (phase)
        P_CHECK: begin
          d_emit = 1'b1;
          if (why != REASON_NONE) begin
            d_res.event_kind = EV_REJECT;
            d_res.reason     = why;
            d_final          = 1'b1;
          end else begin
            d_res.event_kind = EV_ACK;
            phase_next       = P_FOK;
          end
        end
        P_FOK: begin
          if ((it_type == TYPE_FOK) && (sres.avail < {{(AVAIL_W-32){1'b0}}, it_qty})) begin
            d_emit           = 1'b1;
            d_res.event_kind = EV_REJECT;
            d_res.reason     = RSN_FOK_SHORT;
            d_final          = 1'b1;
          end else begin
            phase_next = P_MATCH;
          end
        end
        P_MATCH: begin
          if (fill_pend) begin
            d_emit                 = 1'b1;
            d_res.event_kind       = EV_FILL;
            d_res.counter_order_id = fill_cid;
            d_res.event_price      = fill_price;
            d_res.event_quantity   = fill_qty;
          end else if ((it_qty > 0) && opp_p && opp_trad) begin
            d_trade = 1'b1;
          end else begin
            phase_next = P_REM;
          end
        end
        P_REM: begin
          d_final = 1'b1;
          if (it_qty > 0) begin
            if ((it_type == TYPE_MARKET) || (it_type == TYPE_IOC)) begin
              d_emit           = 1'b1;
              d_res.event_kind = EV_CANCELLED;
              d_res.reason     = RSN_LEFTOVER;
            end else if (it_type != TYPE_FOK) begin
              if (sres.free_found) begin
                d_rest = 1'b1;
              end else begin
                d_emit           = 1'b1;
                d_res.event_kind = EV_CANCELLED;
                d_res.reason     = BOOK_FULL;
              end
            end
          end
        end
        default: begin
          d_final = 1'b1;
        end
      endcase
    end else begin
      d_emit  = 1'b1;
      d_final = 1'b1;
      if (sres.found) begin
        d_res.event_kind     = (it_mode == MODE_CANCEL) ? EV_CANCELLED : EV_QUERY_FOUND;
        d_res.event_side     = sres.found_ent.side;
        d_res.event_price    = sres.found_ent.price;
        d_res.event_quantity = sres.found_ent.remaining;
        d_drop               = (it_mode == MODE_CANCEL);
      end else begin
        d_res.event_kind     = (it_mode == MODE_CANCEL) ? EV_CANCEL_MISS : EV_QUERY_MISS;
        d_res.event_side     = 1'b0;
        d_res.event_price    = 32'sd0;
        d_res.event_quantity = 32'sd0;
      end
    end
  end

  // act on a decision that emits a result only once any earlier result has been pushed out
  assign do_decide  = (state == S_DECIDE) && !(d_emit && pend_valid);
  assign scan_clear = (accept && (orders.mode != MODE_NONE)) || (do_decide && d_trade);
  assign out_load   = (state == S_FLUSH) && (!out_valid || events.ready);

  always_comb begin
    flush_res      = pend;
    flush_res.last = flush_last;
  end

  always_comb begin
    mem_we = do_decide && (d_trade || d_rest);
    mem_wa = d_trade ? opp_idx : free_idx;
    if (d_trade) begin
      mem_wd           = opp;
      mem_wd.remaining = opp.remaining - traded;
    end else begin
      mem_wd.oid         = it_id;
      mem_wd.side        = it_side;
      mem_wd.price       = it_price;
      mem_wd.remaining   = it_qty;
      mem_wd.participant = it_part;
    end
  end

  lobm_slot_mem #(.ORDER_SLOTS(ORDER_SLOTS), .ARRIVAL_BITS(ARRIVAL_BITS)) u_mem (
    .clk    (clk),
    .we     (mem_we),
    .arr_we (do_decide && d_rest),
    .wa     (mem_wa),
    .wd     (mem_wd),
    .warr   (arrival_ctr),
    .re     ((state == S_SCAN) && !issue_done),
    .ra     (scan_addr),
    .rd     (rd_ent),
    .rd_arr (rd_arr)
  );

  lobm_scan #(.ORDER_SLOTS(ORDER_SLOTS), .ARRIVAL_BITS(ARRIVAL_BITS)) u_scan (
    .clk       (clk),
    .clear     (scan_clear),
    .ent_vld   (rd_vld),
    .ent_idx   (rd_idx),
    .ent_live  (slot_valid[rd_idx]),
    .ent       (rd_ent),
    .ent_arr   (rd_arr),
    .ctx       (ctx),
    .res       (sres),
    .found_idx (found_idx),
    .free_idx  (free_idx),
    .bid_idx   (bid_idx),
    .ask_idx   (ask_idx)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      phase       <= P_CHECK;
      book_instr  <= 16'd1;
      slot_valid  <= '0;
      arrival_ctr <= '0;
      pend_valid  <= 1'b0;
      fill_pend   <= 1'b0;
      out_valid   <= 1'b0;
      rd_vld      <= 1'b0;
      issue_done  <= 1'b0;
      scan_addr   <= '0;
      flush_last  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        book_instr <= cfg_wr_data;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (events.ready) begin
        out_valid <= 1'b0;
      end
      rd_vld <= (state == S_SCAN) && !issue_done;
      if (scan_clear) begin
        scan_addr  <= '0;
        issue_done <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            it_mode   <= orders.mode;
            it_id     <= orders.req_id;
            it_instr  <= orders.instrument_code;
            it_side   <= orders.side;
            it_type   <= orders.order_type;
            it_price  <= orders.price;
            it_qty    <= orders.quantity;
            it_part   <= orders.participant_id;
            phase     <= P_CHECK;
            fill_pend <= 1'b0;
            if (orders.mode != MODE_NONE) begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (!issue_done) begin
            rd_idx <= scan_addr;
            if (scan_addr == SLOT_W'(ORDER_SLOTS - 1)) begin
              issue_done <= 1'b1;
            end else begin
              scan_addr <= scan_addr + 1'b1;
            end
          end
          if (rd_vld && (rd_idx == SLOT_W'(ORDER_SLOTS - 1))) begin
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (!do_decide) begin
            flush_last <= 1'b0;
            state      <= S_FLUSH;
          end else begin
            phase <= phase_next;
            if (d_emit) begin
              pend       <= d_res;
              pend_valid <= 1'b1;
              fill_pend  <= 1'b0;
            end
            if (d_trade) begin
              it_qty     <= it_qty - traded;
              fill_cid   <= opp.oid;
              fill_price <= opp.price;
              fill_qty   <= traded;
              fill_pend  <= 1'b1;
              if (opp.remaining == traded) begin
                slot_valid[opp_idx] <= 1'b0;
              end
            end
            if (d_rest) begin
              slot_valid[free_idx] <= 1'b1;
              arrival_ctr          <= arrival_ctr + 1'b1;
            end
            if (d_drop) begin
              slot_valid[found_idx] <= 1'b0;
            end
            if (d_final) begin
              if (d_emit || pend_valid) begin
                flush_last <= 1'b1;
                state      <= S_FLUSH;
              end else begin
                state <= S_IDLE;
              end
            end else if (d_trade) begin
              state <= S_SCAN;
            end
          end
        end
        S_FLUSH: begin
          if (out_load) begin
            out_r      <= flush_res;
            pend_valid <= 1'b0;
            state      <= flush_last ? S_IDLE : S_DECIDE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign events.valid            = out_valid;
  assign events.event_kind       = out_r.event_kind;
  assign events.event_order_id   = out_r.event_order_id;
  assign events.counter_order_id = out_r.counter_order_id;
  assign events.event_side       = out_r.event_side;
  assign events.event_price      = out_r.event_price;
  assign events.event_quantity   = out_r.event_quantity;
  assign events.reason           = out_r.reason;
  assign events.best_bid_price   = out_r.best_bid_price;
  assign events.bid_present      = out_r.bid_present;
  assign events.best_ask_price   = out_r.best_ask_price;
  assign events.ask_present      = out_r.ask_present;
  assign events.last             = out_r.last;

endmodule

### src/lobm_checker.sv
`timescale 1ns / 1ps
module lobm_checker import lobm_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic [1:0]         in_mode,
  input logic               out_valid,
  input logic               out_ready,
  input logic [2:0]         kind,
  input logic [31:0]        counter_id,
  input logic [3:0]         reason,
  input logic               last,
  input logic               bid_present,
  input logic signed [31:0] top_bid
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (in_mode != MODE_NONE) |=> !in_ready)
    else $error("request taken while busy");

  a_fill_counter: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == EV_FILL) |-> (counter_id != 32'd0))
    else $error("fill without resting order id");

  a_empty_bid: assert property (@(posedge clk) disable iff (rst)
    out_valid && !bid_present |-> (top_bid == 32'sd0))
    else $error("bid price on empty side");

  a_miss_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && ((kind == EV_CANCEL_MISS) || (kind == EV_QUERY_MISS))
      |-> last && (reason == REASON_NONE))
    else $error("not-found result malformed");

endmodule

bind limit_order_book_matcher_core lobm_checker u_lobm_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (orders.valid),
  .in_ready    (orders.ready),
  .in_mode     (orders.mode),
  .out_valid   (events.valid),
  .out_ready   (events.ready),
  .kind        (events.event_kind),
  .counter_id  (events.counter_order_id),
  .reason      (events.reason),
  .last        (events.last),
  .bid_present (events.bid_present),
  .top_bid     (events.best_bid_price)
);

### tb/limit_order_book_matcher_core_tb.sv
`timescale 1ns / 1ps
module limit_order_book_matcher_core_tb;
  import lobm_pkg::*;

  localparam int NSLOT = ORDER_SLOTS_DEF;

  typedef struct {
    logic [1:0]  mode;
    logic [31:0] id;
    logic [15:0] instr;
    logic        side;
    logic [2:0]  otype;
    int          price;
    int          qty;
    logic [15:0] part;
  } order_t;

  logic clk;
  logic rst;
  logic cfg_wr_en;
  logic [15:0] cfg_wr_data;

  lobm_order_if orders();
  lobm_event_if events();

  limit_order_book_matcher_core dut (
    .clk(clk), .rst(rst), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .orders(orders.sink), .events(events.source)
  );

  // book copy used for prediction
  bit          bk_valid[NSLOT];
  logic [31:0] bk_id[NSLOT];
  bit          bk_side[NSLOT];
  int          bk_price[NSLOT];
  int          bk_rem[NSLOT];
  logic [15:0] bk_part[NSLOT];
  int unsigned bk_arr[NSLOT];
  int unsigned arrival_ctr;
  logic [15:0] book_instr;

  order_t pending_orders[$];
  order_t on_bus;
  res_t   expected_events[$];
  res_t   batch[$];
  int     src_idle, snk_idle;
  int     errors, n_events, n_fills, n_orders;
  int     stall_req, stall_seen, stall_left;

  function automatic int best_of(bit s);
    int b;
    b = -1;
    for (int i = 0; i < NSLOT; i++) begin
      if (!bk_valid[i] || bk_side[i] != s) continue;
      if (b < 0) b = i;
      else if (bk_price[i] != bk_price[b]) begin
        if (s == 1'b0 ? bk_price[i] > bk_price[b] : bk_price[i] < bk_price[b]) b = i;
      end else if (bk_arr[i] < bk_arr[b]) b = i;
    end
    return b;
  endfunction

  function automatic bit can_trade(int i, bit s, bit mkt, int p);
    if (!bk_valid[i] || bk_side[i] == s) return 0;
    if (mkt) return 1;
    return s == 1'b0 ? bk_price[i] <= p : bk_price[i] >= p;
  endfunction

  function automatic int find_order(logic [31:0] id);
    for (int i = 0; i < NSLOT; i++)
      if (bk_valid[i] && bk_id[i] == id) return i;
    return -1;
  endfunction

  task automatic enq(order_t o);
    pending_orders.insert(pending_orders.size(), o);
  endtask

  task automatic post(logic [2:0] kind, logic [31:0] id, logic [31:0] ctr, bit s, int p,
                      int q, logic [3:0] why);
    res_t r;
    int bb, ba;
    bb = best_of(1'b0);
    ba = best_of(1'b1);
    r.event_kind = kind;
    r.event_order_id = id;
    r.counter_order_id = ctr;
    r.event_side = s;
    r.event_price = p;
    r.event_quantity = q;
    r.reason = why;
    r.best_bid_price = bb >= 0 ? bk_price[bb] : 0;
    r.bid_present = bb >= 0;
    r.best_ask_price = ba >= 0 ? bk_price[ba] : 0;
    r.ask_present = ba >= 0;
    r.last = 1'b0;
    batch.insert(batch.size(), r);
  endtask

  task automatic submit_order(order_t o);
    logic [15:0] ins;
    logic [3:0]  why;
    bit          mkt;
    int          q, b, f, tr;
    longint      avail;
    ins = o.instr == 0 ? book_instr : o.instr;
    mkt = o.otype == TYPE_MARKET;
    why = REASON_NONE;
    q = o.qty;
    if (o.id == 0) why = RSN_NO_ID;
    else if (ins != book_instr) why = WRONG_INSTRUMENT;
    else if (o.qty <= 0) why = RSN_BAD_QTY;
    else if (find_order(o.id) >= 0) why = RSN_DUP_ID;
    else if (!mkt && o.price <= 0) why = RSN_BAD_PRICE;
    else if (o.part != 0) begin
      for (int i = 0; i < NSLOT; i++)
        if (can_trade(i, o.side, mkt, o.price) && bk_part[i] == o.part) why = RSN_SELF_TRADE;
    end
    if (why != REASON_NONE) begin
      post(EV_REJECT, o.id, 0, o.side, o.price, o.qty, why);
      return;
    end
    post(EV_ACK, o.id, 0, o.side, o.price, o.qty, REASON_NONE);
    if (o.otype == TYPE_FOK) begin
      avail = 0;
      for (int i = 0; i < NSLOT; i++)
        if (can_trade(i, o.side, mkt, o.price)) avail += bk_rem[i];
      if (avail < o.qty) begin
        post(EV_REJECT, o.id, 0, o.side, o.price, o.qty, RSN_FOK_SHORT);
        return;
      end
    end
    while (q > 0) begin
      b = best_of(!o.side);
      if (b < 0 || !can_trade(b, o.side, mkt, o.price)) break;
      tr = q < bk_rem[b] ? q : bk_rem[b];
      q -= tr;
      bk_rem[b] -= tr;
      if (bk_rem[b] == 0) bk_valid[b] = 0;
      post(EV_FILL, o.id, bk_id[b], o.side, bk_price[b], tr, REASON_NONE);
    end
    if (q > 0) begin
      if (o.otype == TYPE_MARKET || o.otype == TYPE_IOC) begin
        post(EV_CANCELLED, o.id, 0, o.side, o.price, q, RSN_LEFTOVER);
      end else if (o.otype != TYPE_FOK) begin
        f = -1;
        for (int i = 0; i < NSLOT; i++)
          if (!bk_valid[i]) begin
            f = i;
            break;
          end
        if (f < 0) begin
          post(EV_CANCELLED, o.id, 0, o.side, o.price, q, BOOK_FULL);
        end else begin
          bk_valid[f] = 1;
          bk_id[f] = o.id;
          bk_side[f] = o.side;
          bk_price[f] = o.price;
          bk_rem[f] = q;
          bk_part[f] = o.part;
          bk_arr[f] = arrival_ctr;
          arrival_ctr++;
        end
      end
    end
  endtask

  task automatic predict_events(order_t o);
    int k;
    batch.delete();
    if (o.mode == MODE_SUBMIT) begin
      submit_order(o);
    end else if (o.mode == MODE_CANCEL) begin
      k = find_order(o.id);
      if (k < 0) post(EV_CANCEL_MISS, o.id, 0, 0, 0, 0, REASON_NONE);
      else begin
        bk_valid[k] = 0;
        post(EV_CANCELLED, o.id, 0, bk_side[k], bk_price[k], bk_rem[k], REASON_NONE);
      end
    end else if (o.mode == MODE_QUERY) begin
      k = find_order(o.id);
      if (k < 0) post(EV_QUERY_MISS, o.id, 0, 0, 0, 0, REASON_NONE);
      else post(EV_QUERY_FOUND, o.id, 0, bk_side[k], bk_price[k], bk_rem[k], REASON_NONE);
    end
    if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
    foreach (batch[i]) expected_events.insert(expected_events.size(), batch[i]);
  endtask

  task automatic chk(string nm, logic [31:0] e, logic [31:0] a);
    if (e !== a) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, nm, e, a);
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // order driver
  always @(posedge clk) begin
    if (rst) begin
      orders.valid <= 1'b0;
    end else begin
      if (orders.valid && orders.ready) begin
        predict_events(on_bus);
        n_orders++;
      end
      if (!orders.valid || orders.ready) begin
        if (pending_orders.size() > 0 && $urandom_range(99) >= src_idle) begin
          on_bus = pending_orders.pop_front();
          orders.valid <= 1'b1;
          orders.mode <= on_bus.mode;
          orders.req_id <= on_bus.id;
          orders.instrument_code <= on_bus.instr;
          orders.side <= on_bus.side;
          orders.order_type <= on_bus.otype;
          orders.price <= on_bus.price;
          orders.quantity <= on_bus.qty;
          orders.participant_id <= on_bus.part;
        end else begin
          orders.valid <= 1'b0;
        end
      end
    end
  end

  // event receiver with a single long hold-off
  always @(posedge clk) begin
    if (rst) begin
      events.ready <= 1'b0;
    end else begin
      if (stall_req != stall_seen) begin
        stall_seen <= stall_req;
        stall_left <= 3000;
        events.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        events.ready <= 1'b0;
      end else begin
        events.ready <= $urandom_range(99) >= snk_idle;
      end
    end
  end

  // event monitor
  always @(posedge clk) begin
    res_t e;
    if (!rst && events.valid && events.ready) begin
      n_events++;
      if (events.event_kind == EV_FILL) n_fills++;
      if (expected_events.size() == 0) begin
        errors++;
        $display("%0t: unexpected event, expected none, actual kind %0d id %0h", $time,
                 events.event_kind, events.event_order_id);
      end else begin
        e = expected_events.pop_front();
        chk("event_kind", e.event_kind, events.event_kind);
        chk("event_order_id", e.event_order_id, events.event_order_id);
        chk("counter_order_id", e.counter_order_id, events.counter_order_id);
        chk("event_side", e.event_side, events.event_side);
        chk("event_price", e.event_price, events.event_price);
        chk("event_quantity", e.event_quantity, events.event_quantity);
        chk("reason", e.reason, events.reason);
        chk("best_bid_price", e.best_bid_price, events.best_bid_price);
        chk("bid_present", e.bid_present, events.bid_present);
        chk("best_ask_price", e.best_ask_price, events.best_ask_price);
        chk("ask_present", e.ask_present, events.ask_present);
        chk("last", e.last, events.last);
      end
    end
  end

  function automatic order_t mk(logic [1:0] m, logic [31:0] id, logic [15:0] ins, bit s,
                                logic [2:0] t, int p, int q, logic [15:0] pt);
    order_t o;
    o.mode = m;
    o.id = id;
    o.instr = ins;
    o.side = s;
    o.otype = t;
    o.price = p;
    o.qty = q;
    o.part = pt;
    return o;
  endfunction

  function automatic order_t rand_order(logic [15:0] ins);
    order_t o;
    int r;
    r = $urandom_range(99);
    if (r < 12) begin
      o = mk(2'($urandom_range(3)), $urandom, 16'($urandom), 1'($urandom_range(1)),
             3'($urandom_range(7)), $urandom, $urandom, 16'($urandom));
      if ($urandom_range(1)) o.id = $urandom_range(80);
    end else begin
      o = mk(r < 72 ? MODE_SUBMIT : (r < 88 ? MODE_CANCEL : MODE_QUERY), $urandom_range(1, 80),
             $urandom_range(3) == 0 ? ins : 16'd0, 1'($urandom_range(1)),
             3'($urandom_range(7)), $urandom_range(95, 105), $urandom_range(1, 60),
             16'($urandom_range(5)));
    end
    return o;
  endfunction

  task automatic settle();
    while (pending_orders.size() > 0 || orders.valid || expected_events.size() > 0)
      @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_instr(logic [15:0] v);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    book_instr = v;
    @(posedge clk);
  endtask

  initial begin
    logic [15:0] ins;
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    orders.valid = 1'b0;
    orders.mode = MODE_NONE;
    orders.req_id = '0;
    orders.instrument_code = '0;
    orders.side = 1'b0;
    orders.order_type = TYPE_LIMIT;
    orders.price = 0;
    orders.quantity = 0;
    orders.participant_id = '0;
    events.ready = 1'b0;
    src_idle = 0;
    snk_idle = 0;
    errors = 0;
    n_events = 0;
    n_fills = 0;
    n_orders = 0;
    stall_req = 0;
    stall_seen = 0;
    stall_left = 0;
    arrival_ctr = 0;
    book_instr = 16'd1;
    foreach (bk_valid[i]) bk_valid[i] = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: each reject reason, every order type, cancel and query paths
    enq(mk(MODE_SUBMIT, 0, 0, 0, TYPE_LIMIT, 100, 10, 0));
    enq(mk(MODE_SUBMIT, 1, 16'hFFFF, 0, TYPE_LIMIT, 100, 10, 0));
    enq(mk(MODE_SUBMIT, 2, 1, 0, TYPE_LIMIT, 100, 0, 0));
    enq(mk(MODE_SUBMIT, 2, 0, 0, TYPE_LIMIT, 100, 32'h80000000, 0));
    enq(mk(MODE_SUBMIT, 3, 0, 0, TYPE_LIMIT, 0, 10, 0));
    enq(mk(MODE_SUBMIT, 3, 0, 1, TYPE_GTC, 32'h80000000, 10, 0));
    enq(mk(MODE_SUBMIT, 10, 0, 0, TYPE_LIMIT, 100, 10, 7));
    enq(mk(MODE_SUBMIT, 10, 0, 1, TYPE_LIMIT, 100, 10, 0));
    enq(mk(MODE_SUBMIT, 11, 0, 0, 3'd7, 101, 5, 0));
    enq(mk(MODE_SUBMIT, 12, 0, 1, TYPE_GTC, 99, 4, 7));
    enq(mk(MODE_SUBMIT, 13, 1, 1, TYPE_FOK, 90, 100, 0));
    enq(mk(MODE_SUBMIT, 14, 0, 1, TYPE_FOK, 90, 6, 0));
    enq(mk(MODE_SUBMIT, 15, 0, 0, TYPE_GTC, 32'h7FFFFFFF, 20, 3));
    enq(mk(MODE_SUBMIT, 16, 0, 1, TYPE_IOC, 32'h7FFFFFFF, 30, 0));
    enq(mk(MODE_SUBMIT, 17, 0, 0, TYPE_LIMIT, 50, 32'h7FFFFFFF, 0));
    enq(mk(MODE_SUBMIT, 18, 0, 1, TYPE_MARKET, -5, 40, 0));
    enq(mk(MODE_QUERY, 17, 0, 0, TYPE_LIMIT, 0, 0, 0));
    enq(mk(MODE_QUERY, 32'hFFFFFFFF, 0, 0, TYPE_LIMIT, 0, 0, 0));
    enq(mk(MODE_CANCEL, 17, 0, 0, TYPE_LIMIT, 0, 0, 0));
    enq(mk(MODE_CANCEL, 17, 0, 0, TYPE_LIMIT, 0, 0, 0));
    enq(mk(MODE_NONE, 5, 0, 1, TYPE_LIMIT, 1, 1, 0));
    enq(mk(MODE_SUBMIT, 19, 0, 0, TYPE_MARKET, 0, 3, 0));
    settle();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          ins = 16'hFFFF;
          src_idle = 32;
          snk_idle = 62;
        end
        1: begin
          ins = 16'd1;
          src_idle = 62;
          snk_idle = 32;
        end
        2: begin
          ins = 16'($urandom_range(2, 65534));
          src_idle = 0;
          snk_idle = 0;
        end
        default: begin
          ins = 16'd1;
          src_idle = 0;
          snk_idle = 0;
        end
      endcase
      write_instr(ins);
      if (ph == 2) stall_req++;
      if (ph == 3) begin
        // fill every slot, then overflow the book
        for (int i = 0; i < NSLOT + 2; i++)
          enq(mk(MODE_SUBMIT, 1000 + i, 0, 0, TYPE_LIMIT, 10, 1, 0));
      end
      for (int i = 0; i < 110; i++) enq(rand_order(ins));
      settle();
    end

    $display("tb: %0d requests accepted, %0d events checked (%0d fills), four instrument settings",
             n_orders, n_events, n_fills);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #60_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
